/* rtl/bcsh_pkg.sv */
// ----------------------------------------------------------------------------
// bcsh_pkg
// shared types, constants and helpers of the bitcrusher sample-hold quantizer
// ----------------------------------------------------------------------------
package bcsh_pkg;

  // build constants
  localparam int unsigned ChannelCount = 2;
  localparam int unsigned SampleW      = 16;
  localparam int unsigned BitsW        = 5;
  localparam int unsigned DownW        = 6;
  localparam int unsigned MixW         = 16;
  localparam int unsigned CntW         = 5;
  localparam int unsigned CfgAddrW     = 2;
  localparam int unsigned CfgDataW     = 16;

  // limits of the effective settings
  localparam logic [BitsW-1:0] BitsMax      = 5'd16;
  localparam logic [DownW-1:0] DownMax      = 6'd32;
  localparam logic [MixW-1:0]  MixFull      = 16'h8000;
  localparam logic [MixW-1:0]  MixBypassMax = 16'd98;

  // configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CfgBitDepth   = 2'd0,
    CfgDownsample = 2'd1,
    CfgWetMix     = 2'd2
  } cfg_idx_e;

  // raw configuration registers as written
  typedef struct packed {
    logic [BitsW-1:0] bit_depth;
    logic [DownW-1:0] downsample_factor;
    logic [MixW-1:0]  wet_mix;
  } cfg_t;

  // item leaving the hold stage
  typedef struct packed {
    logic signed [SampleW-1:0] x;       // dry sample
    logic signed [SampleW-1:0] h;       // held sample
    logic                      bypass;  // pass dry sample unchanged
    logic [3:0]                k;       // log2 of the quantizer step
    logic [MixW-1:0]           mix;     // effective wet weight, 0..32768
  } hold_item_t;

  // round h to the nearest multiple of 2^k, ties upward; result -32768..32768
  function automatic logic signed [17:0] quantize(logic signed [15:0] h, logic [3:0] k);
    logic [16:0] half;
    logic [16:0] mask;
    logic [16:0] biased;
    half   = (k == 4'd0) ? 17'd0 : (17'd1 << (k - 4'd1));
    mask   = ~((17'd1 << k) - 17'd1);
    biased = {1'b0, ~h[15], h[14:0]} + half;
    quantize = $signed({1'b0, biased & mask}) - 18'sd32768;
  endfunction

endpackage

/* rtl/bitcrusher_sample_hold_quantizer.sv */
// ----------------------------------------------------------------------------
// bitcrusher_sample_hold_quantizer
// bit-depth reduction with per-channel sample-and-hold and dry/wet mix
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one item per sample: tdata[15:0] is the signed sample,
//   tuser[0] the channel (0 left or mono, 1 right). m_axis returns one item
//   per accepted item, in order, tdata[15:0] the processed signed sample.
//   settings are written through cfg_we_i / cfg_addr_i / cfg_wdata_i while
//   the block is idle: 0 bit depth, 1 downsample factor, 2 wet mix (Q15).
// timing:
//   items pass the hold stage register, then the five-stage mixing pipeline,
//   to m_axis_tvalid; throughput is one item per cycle while m_axis_tready is
//   high. the hold stage updates the channel state in the cycle an item is
//   accepted, so the same channel may follow in the next cycle.
// reset:
//   clears the hold counters and held samples, empties the pipeline and
//   loads bit depth 16, downsample 1, wet mix 0 (bypass).
// stall:
//   when m_axis_tready is low the output holds; earlier stages keep filling
//   until the pipeline is full, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module bitcrusher_sample_hold_quantizer #(
  parameter int unsigned CHANNEL_COUNT = bcsh_pkg::ChannelCount
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [bcsh_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [bcsh_pkg::CfgDataW-1:0] cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [15:0] sample_in
  input  logic [0:0]                    s_axis_tuser,  // [0] channel
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata   // [15:0] sample_out
);
  import bcsh_pkg::*;

  cfg_t                 cfg_q;
  logic                 hold_valid;
  logic                 hold_ready;
  hold_item_t           hold_item;
  logic signed [15:0]   sample_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_depth         <= BitsMax;
      cfg_q.downsample_factor <= 6'd1;
      cfg_q.wet_mix           <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CfgBitDepth:   cfg_q.bit_depth         <= cfg_wdata_i[BitsW-1:0];
        CfgDownsample: cfg_q.downsample_factor <= cfg_wdata_i[DownW-1:0];
        CfgWetMix:     cfg_q.wet_mix           <= cfg_wdata_i[MixW-1:0];
        default: ;
      endcase
    end
  end

  // channel state and input stage
  bcsh_hold #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_hold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i    ($signed(s_axis_tdata)),
    .channel_i   (s_axis_tuser[0]),
    .out_valid_o (hold_valid),
    .out_ready_i (hold_ready),
    .out_item_o  (hold_item)
  );

  // mixing pipeline and output register
  bcsh_mix u_mix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (hold_valid),
    .in_ready_o   (hold_ready),
    .in_item_i    (hold_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .sample_out_o (sample_out)
  );

  assign m_axis_tdata = sample_out;

`ifndef SYNTH
  // an empty output means every stage can load, so input is never refused
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input refused while output stage is empty");

  // the pipeline comes out of reset empty
  assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

/* rtl/bcsh_hold.sv */
// ----------------------------------------------------------------------------
// bcsh_hold
// per-channel hold counters and held samples, effective settings, input stage
// ----------------------------------------------------------------------------
module bcsh_hold #(
  parameter int unsigned CHANNEL_COUNT = bcsh_pkg::ChannelCount
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bcsh_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [15:0]         sample_i,
  input  logic                       channel_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bcsh_pkg::hold_item_t       out_item_o
);
  import bcsh_pkg::*;

  localparam int unsigned ChW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  logic [BitsW-1:0]          bits_eff;
  logic [DownW-1:0]          down_eff;
  logic [MixW-1:0]           mix_eff;
  logic                      bypass;
  logic [ChW-1:0]            ch_idx;
  logic                      fire;
  logic [CntW-1:0]           cnt_cur;
  logic [CntW:0]             cnt_inc;
  logic [CntW-1:0]           cnt_next;
  logic signed [SampleW-1:0] h_cur;

  logic [CntW-1:0]           cnt_q    [CHANNEL_COUNT];
  logic [CntW-1:0]           cnt_d    [CHANNEL_COUNT];
  logic signed [SampleW-1:0] held_q   [CHANNEL_COUNT];
  logic signed [SampleW-1:0] held_d   [CHANNEL_COUNT];
  logic                      valid_q;
  hold_item_t                item_q;
  hold_item_t                item_d;

  // saturate the settings to their legal ranges
  always_comb begin
    if (cfg_i.bit_depth == '0) begin
      bits_eff = 5'd1;
    end else if (cfg_i.bit_depth > BitsMax) begin
      bits_eff = BitsMax;
    end else begin
      bits_eff = cfg_i.bit_depth;
    end
    if (cfg_i.downsample_factor == '0) begin
      down_eff = 6'd1;
    end else if (cfg_i.downsample_factor > DownMax) begin
      down_eff = DownMax;
    end else begin
      down_eff = cfg_i.downsample_factor;
    end
    mix_eff = (cfg_i.wet_mix > MixFull) ? MixFull : cfg_i.wet_mix;
  end

  assign bypass = ((bits_eff == BitsMax) && (down_eff == 6'd1)) || (mix_eff <= MixBypassMax);

  // channel select, out-of-range channels fold onto channel 0
  assign ch_idx = (32'(channel_i) < CHANNEL_COUNT) ? ChW'(channel_i) : '0;

  assign in_ready_o = !valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // counter step and held value for the selected channel
  assign cnt_cur  = cnt_q[ch_idx];
  assign cnt_inc  = {1'b0, cnt_cur} + 6'd1;
  assign cnt_next = (cnt_inc >= down_eff) ? '0 : cnt_inc[CntW-1:0];
  assign h_cur    = (cnt_cur == '0) ? sample_i : held_q[ch_idx];

  // channel state next values, bypassed items leave the state alone
  always_comb begin
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      cnt_d[c]  = cnt_q[c];
      held_d[c] = held_q[c];
      if (fire && !bypass && (ch_idx == ChW'(c))) begin
        cnt_d[c] = cnt_next;
        if (cnt_cur == '0) begin
          held_d[c] = sample_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        cnt_q[c]  <= '0;
        held_q[c] <= '0;
      end
    end else begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        cnt_q[c]  <= cnt_d[c];
        held_q[c] <= held_d[c];
      end
    end
  end

  // stage register payload
  always_comb begin
    item_d.x      = sample_i;
    item_d.h      = h_cur;
    item_d.bypass = bypass;
    item_d.k      = 4'(BitsMax - bits_eff);
    item_d.mix    = mix_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

/* rtl/bcsh_mix.sv */
// ----------------------------------------------------------------------------
// bcsh_mix
// quantize, dry/wet mix, clamp and 32767 scaling over five pipeline stages
// ----------------------------------------------------------------------------
module bcsh_mix (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bcsh_pkg::hold_item_t in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [15:0]   sample_out_o
);
  import bcsh_pkg::*;

  localparam logic signed [32:0] NLimit = 33'sd1073741824;

  // stage valid bits and load enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic r1, r2, r3, r4, r5;

  // stage 1: quantized held value
  logic signed [SampleW-1:0] x1_q;
  logic signed [17:0]        q1_q;
  logic [MixW-1:0]           m1_q;
  logic                      byp1_q;

  // stage 2: products
  logic signed [SampleW-1:0] x2_q;
  logic signed [31:0]        px2_q, pq2_q;
  logic signed [31:0]        px2_d, pq2_d;
  logic                      byp2_q;
  logic [MixW-1:0]           w1;
  logic signed [33:0]        px_full;
  logic signed [34:0]        pq_full;

  // stage 3: mix sum
  logic signed [SampleW-1:0] x3_q;
  logic signed [32:0]        n3_q;
  logic                      byp3_q;

  // stage 4: clamped magnitude and sign
  logic signed [SampleW-1:0] x4_q;
  logic [30:0]               mag4_q;
  logic [30:0]               mag4_d;
  logic                      neg4_q;
  logic                      byp4_q;

  // stage 5: output register
  logic signed [SampleW-1:0] out5_q;
  logic signed [SampleW-1:0] out5_d;
  logic [45:0]               scaled;
  logic [15:0]               res;

  assign r5 = !v5_q || out_ready_i;
  assign r4 = !v4_q || r5;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_ready_o = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
      if (r5) v5_q <= v4_q;
    end
  end

  // products of dry and wet with their weights
  assign w1      = MixFull - m1_q;
  assign px_full = $signed({x1_q[SampleW-1], x1_q}) * $signed({1'b0, w1});
  assign pq_full = q1_q * $signed({1'b0, m1_q});
  assign px2_d   = px_full[31:0];
  assign pq2_d   = pq_full[31:0];

  // clamp to +-1.0 and split into sign and magnitude
  always_comb begin
    logic signed [32:0] nc;
    nc = n3_q;
    if (n3_q > NLimit) begin
      nc = NLimit;
    end else if (n3_q < -NLimit) begin
      nc = -NLimit;
    end
    mag4_d = nc[32] ? 31'(-nc) : nc[30:0];
  end

  // scale by 32767 / 2^30 toward zero, bypassed items pass the dry sample
  assign scaled = {mag4_q, 15'd0} - {15'd0, mag4_q};
  assign res    = scaled[45:30];
  always_comb begin
    if (byp4_q) begin
      out5_d = x4_q;
    end else if (neg4_q) begin
      out5_d = -$signed(res);
    end else begin
      out5_d = $signed(res);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (r1 && in_valid_i) begin
      x1_q   <= in_item_i.x;
      q1_q   <= quantize(in_item_i.h, in_item_i.k);
      m1_q   <= in_item_i.mix;
      byp1_q <= in_item_i.bypass;
    end
    if (r2 && v1_q) begin
      x2_q   <= x1_q;
      px2_q  <= px2_d;
      pq2_q  <= pq2_d;
      byp2_q <= byp1_q;
    end
    if (r3 && v2_q) begin
      x3_q   <= x2_q;
      n3_q   <= $signed({px2_q[31], px2_q}) + $signed({pq2_q[31], pq2_q});
      byp3_q <= byp2_q;
    end
    if (r4 && v3_q) begin
      x4_q   <= x3_q;
      mag4_q <= mag4_d;
      neg4_q <= n3_q[32];
      byp4_q <= byp3_q;
    end
    if (r5 && v4_q) begin
      out5_q <= out5_d;
    end
  end

  assign out_valid_o  = v5_q;
  assign sample_out_o = out5_q;

endmodule

/* dv/bitcrusher_sample_hold_quantizer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitcrusher_sample_hold_quantizer_tb
// self-checking bench for the bit-depth reducer with sample-and-hold and mix
// ----------------------------------------------------------------------------
// a directed burst walks the sample extremes, the bypass rules, clamped
// settings and the hold counter wrap; random phases follow, each under new
// settings and one of four rotating mixes of sender gaps and receiver stalls,
// one of them with a long receiver hold-off. every accepted sample is run
// through a bit exact predictor and the outputs are compared in order.
// ----------------------------------------------------------------------------
module bitcrusher_sample_hold_quantizer_tb;

  import bcsh_pkg::*;

  localparam int unsigned LATENCY         = 5;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned RAND_PHASES     = 12;
  localparam int unsigned PHASE_ITEMS     = 75;
  localparam longint     TIMEOUT_NS      = 2_000_000;

  // expected output of the crusher, kept in step with accepted samples
  class crush_predictor;
    logic [BitsW-1:0]     bits_reg;
    logic [DownW-1:0]     down_reg;
    logic [MixW-1:0]      mix_reg;
    int unsigned          cnt_per_ch [ChannelCount];
    logic signed [15:0]   held [ChannelCount];
    logic [15:0]          expected_out [$];
    int unsigned          n_in;
    int unsigned          n_out;
    int unsigned          n_bad;

    function void clear();
      bits_reg = BitsMax;
      down_reg = 6'd1;
      mix_reg  = '0;
      for (int i = 0; i < ChannelCount; i++) begin
        cnt_per_ch[i] = 0;
        held[i]       = '0;
      end
      expected_out.delete();
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CfgBitDepth: begin
          bits_reg = val[BitsW-1:0];
        end
        CfgDownsample: begin
          down_reg = val[DownW-1:0];
        end
        CfgWetMix: begin
          mix_reg = val[MixW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void flag(string what);
      n_bad++;
      if (n_bad <= 10) $display("%t mismatch: %s", $realtime, what);
    endfunction

    // work out the result of one accepted sample and queue it
    function void note_sample(logic signed [15:0] smp, logic ch);
      int     b;
      int     d;
      int     c;
      int     k;
      longint m;
      longint x;
      longint h;
      longint q;
      longint half;
      longint n;
      longint mag;
      n_in++;
      b = (bits_reg < 1) ? 1 : ((bits_reg > 16) ? 16 : int'(bits_reg));
      d = (down_reg < 1) ? 1 : ((down_reg > 32) ? 32 : int'(down_reg));
      m = (mix_reg > 32768) ? 32768 : longint'(mix_reg);
      x = smp;
      // bypass leaves the hold state alone
      if ((b == 16 && d == 1) || m <= 98) begin
        expected_out.push_back(smp);
        return;
      end
      c = (int'(ch) < ChannelCount) ? int'(ch) : 0;
      if (cnt_per_ch[c] == 0) held[c] = smp;
      h = held[c];
      cnt_per_ch[c]++;
      if (cnt_per_ch[c] >= d) cnt_per_ch[c] = 0;
      // round to the step grid, ties upward
      k    = 16 - b;
      half = (longint'(1) << k) >> 1;
      q    = (((h + 32768 + half) >> k) << k) - 32768;
      // Q30 mix, clamp to full scale, scale by 32767 toward zero
      n = x * (32768 - m) + q * m;
      if (n > (longint'(1) << 30)) n = longint'(1) << 30;
      if (n < -(longint'(1) << 30)) n = -(longint'(1) << 30);
      mag = ((n < 0) ? -n : n) * 32767 / (longint'(1) << 30);
      if (n < 0) mag = -mag;
      expected_out.push_back(mag[15:0]);
    endfunction

    function void check_output(logic [15:0] got);
      logic [15:0] want;
      n_out++;
      if (expected_out.size() == 0) begin
        flag($sformatf("unexpected sample_out %0d", $signed(got)));
        return;
      end
      want = expected_out.pop_front();
      if (got !== want) begin
        flag($sformatf("sample_out expected %0d got %0d", $signed(want), $signed(got)));
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i  = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;  // [15:0] sample_in
  logic [0:0]  s_axis_tuser  = '0;  // [0] channel
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] sample_out

  crush_predictor sb;
  int unsigned    snd_idle_pct = 0;
  int unsigned    rcv_stall_pct = 0;
  logic           rcv_hold = 1'b0;
  int unsigned    n_settings = 0;
  event           hold_off_go;

  bitcrusher_sample_hold_quantizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: check accepted items, then pick next cycle's ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
      m_axis_tready <= !rcv_hold && ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // long receiver hold-off so the pipeline fills and backs up the input
  initial begin
    forever begin
      @(hold_off_go);
      rcv_hold <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      rcv_hold <= 1'b0;
    end
  end

  // hard stop
  initial begin
    #(TIMEOUT_NS);
    $display("bitcrusher_sample_hold_quantizer regression: fail");
    $finish;
  end

  // offer one item, with random gaps ahead of it, and wait for acceptance
  task automatic send_item(input logic [15:0] smp, input logic ch);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= ch;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_sample(smp, ch);
  endtask

  // drop valid after a burst and let every result come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_out.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // write all three registers while the block is idle
  task automatic load_settings(input logic [15:0] bits, input logic [15:0] down,
                               input logic [15:0] mix);
    drain();
    n_settings++;
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CfgBitDepth;
    cfg_wdata_i <= bits;
    @(posedge clk_i);
    sb.set_reg(CfgBitDepth, bits);
    cfg_addr_i  <= CfgDownsample;
    cfg_wdata_i <= down;
    @(posedge clk_i);
    sb.set_reg(CfgDownsample, down);
    cfg_addr_i  <= CfgWetMix;
    cfg_wdata_i <= mix;
    @(posedge clk_i);
    sb.set_reg(CfgWetMix, mix);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // settings biased toward the working range, with extremes and clamped values
  task automatic load_random_settings();
    logic [15:0] bits;
    logic [15:0] down;
    logic [15:0] mix;
    case ($urandom_range(5))
      0: bits = 16'($urandom_range(31));
      1: bits = 16'd16;
      2: bits = 16'd1;
      default: bits = 16'($urandom_range(15, 1));
    endcase
    case ($urandom_range(5))
      0: down = 16'($urandom_range(63));
      1: down = 16'd32;
      default: down = 16'($urandom_range(8, 1));
    endcase
    case ($urandom_range(9))
      0: mix = 16'd98;
      1: mix = 16'd99;
      2: mix = 16'h8000;
      3: mix = 16'($urandom_range(16'hffff));
      default: mix = 16'($urandom_range(32768, 99));
    endcase
    load_settings(bits, down, mix);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: pick_sample = 16'h8000;
      1: pick_sample = 16'h7fff;
      2: pick_sample = 16'($signed($urandom_range(600)) - 300);
      default: pick_sample = 16'($urandom);
    endcase
  endfunction

  // main sequence
  initial begin
    sb = new();
    sb.clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings bypass, full scale negative passes untouched
    send_item(16'h8000, 1'b0);
    send_item(16'h7fff, 1'b1);
    send_item(16'h0000, 1'b0);

    // one bit, fully wet: the extremes land on the clamp
    load_settings(16'd1, 16'd1, 16'h8000);
    send_item(16'h8000, 1'b0);
    send_item(16'h7fff, 1'b1);
    send_item(16'hc000, 1'b0);
    send_item(16'h3fff, 1'b1);
    send_item(16'hffff, 1'b0);

    // out-of-range settings clamp to the nearest legal value
    load_settings(16'd0, 16'd0, 16'hffff);
    send_item(16'h7fff, 1'b0);
    send_item(16'h8001, 1'b1);

    // mix at the bypass edge with the other settings above range
    load_settings(16'd31, 16'd63, 16'd98);
    send_item(16'h8000, 1'b1);
    send_item(16'h1234, 1'b0);

    // full depth with hold active and mix just past bypass
    load_settings(16'd16, 16'd3, 16'd99);
    send_item(16'h8000, 1'b0);
    send_item(16'd100, 1'b1);
    send_item(16'd5, 1'b0);
    send_item(16'd7, 1'b0);
    send_item(16'd9, 1'b1);

    // long hold, then the factor drops below the running count
    load_settings(16'd12, 16'd32, 16'd20000);
    send_item(16'h4321, 1'b0);
    send_item(16'h0101, 1'b0);
    send_item(16'hbeef, 1'b0);
    load_settings(16'd12, 16'd2, 16'd20000);
    send_item(16'h1111, 1'b0);
    send_item(16'h2222, 1'b0);

    // random phases, each with one of four idle patterns in turn
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: load_settings(16'd1, 16'd32, 16'h8000);
        1: load_settings(16'd8, 16'd5, 16'd16384);
        default: load_random_settings();
      endcase
      case (ph % 4)
        0: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
        end
        1: begin
          snd_idle_pct  = 65;
          rcv_stall_pct = 0;
        end
        2: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 65;
        end
        default: begin
          snd_idle_pct  = 31;
          rcv_stall_pct = 31;
        end
      endcase
      if (ph == 4) -> hold_off_go;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_item(pick_sample(), 1'($urandom_range(1)));
      end
    end
    drain();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (sb.expected_out.size() != 0) begin
      sb.flag($sformatf("%0d results never arrived", sb.expected_out.size()));
    end

    $display("run: %0d samples in, %0d checked, %0d settings loaded",
             sb.n_in, sb.n_out, n_settings);
    $display("mismatches: %0d", sb.n_bad);
    if (sb.n_bad == 0) begin
      $display("bitcrusher_sample_hold_quantizer regression: pass");
    end else begin
      $display("bitcrusher_sample_hold_quantizer regression: fail");
    end
    $finish;
  end

endmodule
